>>> design/dccenc_pkg.sv
package dccenc_pkg;

	// Request codes carried in req_type.
	localparam logic REQ_LOAD = 1'b0;
	localparam logic REQ_TICK = 1'b1;

	// Address of the idle packet.
	localparam logic [7:0] IDLE_ADDRESS = 8'hFF;

	// One accepted request item.
	typedef struct packed {
		logic       req_type;
		logic [7:0] address_byte;
		logic [7:0] instruction_byte;
	} req_t;

	// One emitted half-bit slot.
	typedef struct packed {
		logic level;
		logic first_slot;
		logic last_slot;
	} slot_t;

endpackage

>>> design/dccenc_if.sv
// Request channel: loads and ticks.
interface dccenc_req_if;
	logic       valid;
	logic       ready;
	logic       req_type;
	logic [7:0] address_byte;
	logic [7:0] instruction_byte;

	modport source (output valid, req_type, address_byte, instruction_byte, input ready);
	modport sink (input valid, req_type, address_byte, instruction_byte, output ready);
endinterface

// Slot channel: one track level per tick.
interface dccenc_slot_if;
	logic valid;
	logic ready;
	logic level;
	logic first_slot;
	logic last_slot;

	modport source (output valid, level, first_slot, last_slot, input ready);
	modport sink (input valid, level, first_slot, last_slot, output ready);
endinterface

>>> design/dccenc_seq.sv
module dccenc_seq
	import dccenc_pkg::*;
#(
	parameter int PREAMBLE_ONES = 14
) (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  step,
	input  req_t  req,
	output slot_t slot
);

	// Packet segment codes.
	localparam logic [2:0] SEG_PREAMBLE    = 3'd0;
	localparam logic [2:0] SEG_SEP0        = 3'd1;
	localparam logic [2:0] SEG_ADDRESS     = 3'd2;
	localparam logic [2:0] SEG_SEP1        = 3'd3;
	localparam logic [2:0] SEG_INSTRUCTION = 3'd4;
	localparam logic [2:0] SEG_SEP2        = 3'd5;
	localparam logic [2:0] SEG_CHECK       = 3'd6;
	localparam logic [2:0] SEG_END         = 3'd7;

	localparam logic [8:0] PRE_SLOTS = 9'(2 * PREAMBLE_ONES);

	logic [7:0] held_address_q;
	logic [7:0] held_instruction_q;
	logic       accessory_pending_q;
	logic [2:0] segment_q;
	logic [2:0] bit_count_q;
	logic [1:0] half_count_q;
	logic [7:0] slot_count_q;

	logic       cur_bit;
	logic [2:0] bit_pos;
	logic       bit_done;
	logic       last;

	// Bit that the current segment sends, data bytes MSB first.
	always_comb begin
		bit_pos = 3'd7 - bit_count_q;
		case (segment_q)
			SEG_PREAMBLE:    cur_bit = 1'b1;
			SEG_ADDRESS:     cur_bit = held_address_q[bit_pos];
			SEG_INSTRUCTION: cur_bit = held_instruction_q[bit_pos];
			SEG_CHECK:       cur_bit = held_address_q[bit_pos] ^ held_instruction_q[bit_pos];
			SEG_END:         cur_bit = 1'b1;
			default:         cur_bit = 1'b0;
		endcase
	end

	// A one is high then low; a zero is two high then two low.
	always_comb begin
		slot.level      = cur_bit ? (half_count_q == 2'd0) : (half_count_q < 2'd2);
		slot.first_slot = (slot_count_q == 8'd0);
		last            = (segment_q == SEG_END) && (half_count_q == 2'd1);
		slot.last_slot  = last;
		bit_done        = cur_bit ? (half_count_q == 2'd1) : (half_count_q == 2'd3);
	end

	// Sequencer state advances once per processed request.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_address_q      <= IDLE_ADDRESS;
			held_instruction_q  <= 8'd0;
			accessory_pending_q <= 1'b0;
			segment_q           <= SEG_PREAMBLE;
			bit_count_q         <= 3'd0;
			half_count_q        <= 2'd0;
			slot_count_q        <= 8'd0;
		end else if (step) begin
			if (req.req_type == REQ_LOAD) begin
				held_address_q      <= req.address_byte;
				held_instruction_q  <= req.instruction_byte;
				accessory_pending_q <= req.address_byte[7] && (req.address_byte != IDLE_ADDRESS);
				segment_q           <= SEG_PREAMBLE;
				bit_count_q         <= 3'd0;
				half_count_q        <= 2'd0;
				slot_count_q        <= 8'd0;
			end else if (last) begin
				// An accessory packet goes out once, then idle packets follow.
				if (accessory_pending_q) begin
					held_address_q      <= IDLE_ADDRESS;
					held_instruction_q  <= 8'd0;
					accessory_pending_q <= 1'b0;
				end
				segment_q    <= SEG_PREAMBLE;
				bit_count_q  <= 3'd0;
				half_count_q <= 2'd0;
				slot_count_q <= 8'd0;
			end else begin
				if (bit_done) begin
					half_count_q <= 2'd0;
					case (segment_q)
						SEG_PREAMBLE: begin
							if ({1'b0, slot_count_q} + 9'd1 >= PRE_SLOTS) begin
								segment_q <= SEG_SEP0;
							end
						end
						SEG_ADDRESS, SEG_INSTRUCTION, SEG_CHECK: begin
							if (bit_count_q == 3'd7) begin
								bit_count_q <= 3'd0;
								segment_q   <= segment_q + 3'd1;
							end else begin
								bit_count_q <= bit_count_q + 3'd1;
							end
						end
						default: begin
							bit_count_q <= 3'd0;
							segment_q   <= segment_q + 3'd1;
						end
					endcase
				end else begin
					half_count_q <= half_count_q + 2'd1;
				end
				slot_count_q <= slot_count_q + 8'd1;
			end
		end
	end

endmodule

>>> design/dcc_packet_symbol_encoder.sv
// A tick accepted into the input register loads its slot into the output register when it moves on,
// and the slot can transfer from there.
// Throughput: one request (load or tick) per cycle while the output is taken.
// A load gives no slot; a tick gives exactly one.
// Reset (arst_n low, asynchronous) empties both registers and holds the
// idle packet (address 0xFF, instruction 0x00) at the start of its preamble.
module dcc_packet_symbol_encoder
	import dccenc_pkg::*;
#(
	parameter int PREAMBLE_ONES = 14
) (
	input logic           clk,
	input logic           arst_n,
	dccenc_req_if.sink    req,
	dccenc_slot_if.source slot
);

	logic  req_valid_s1;
	req_t  req_s1;
	logic  out_valid_q;
	slot_t out_q;
	slot_t slot_next;
	logic  advance;

	// The registered request moves on unless its slot would overwrite one not yet taken.
	assign advance   = req_valid_s1 &&
		((req_s1.req_type == REQ_LOAD) || !out_valid_q || slot.ready);
	assign req.ready = !req_valid_s1 || advance;

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_valid_s1 <= 1'b0;
		end else if (req.ready) begin
			req_valid_s1 <= req.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (req.ready && req.valid) begin
			req_s1.req_type         <= req.req_type;
			req_s1.address_byte     <= req.address_byte;
			req_s1.instruction_byte <= req.instruction_byte;
		end
	end

	dccenc_seq #(
		.PREAMBLE_ONES(PREAMBLE_ONES)
	) u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (advance),
		.req    (req_s1),
		.slot   (slot_next)
	);

	// Output register: a tick loads it, a transfer empties it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance && (req_s1.req_type == REQ_TICK)) begin
			out_valid_q <= 1'b1;
		end else if (slot.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && (req_s1.req_type == REQ_TICK)) begin
			out_q <= slot_next;
		end
	end

	assign slot.valid      = out_valid_q;
	assign slot.level      = out_q.level;
	assign slot.first_slot = out_q.first_slot;
	assign slot.last_slot  = out_q.last_slot;

	// The end slot of a packet is always low.
	a_last_low: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_q.last_slot) |-> !out_q.level)
		else $error("end slot is not low");

	// A packet never starts and ends in the same slot.
	a_first_not_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> !(out_q.first_slot && out_q.last_slot))
		else $error("slot flagged both first and last");

	// The input stalls only behind a pending tick and a full, untaken output.
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!req.ready |-> (req_valid_s1 && (req_s1.req_type == REQ_TICK) &&
			out_valid_q && !slot.ready))
		else $error("input stalled without cause");

	// A tick that moves on fills the output in the next cycle.
	a_tick_fills: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && (req_s1.req_type == REQ_TICK)) |=> out_valid_q)
		else $error("tick produced no slot");

endmodule
